/* design/rwcs_pkg.sv */
// Package with the item types, codes and constants of the wall column setup block.
`timescale 1ns / 1ps
package rwcs_pkg;

    localparam int SCREEN_HEIGHT_DEF = 1024;
    localparam int TEXTURE_SIZE_DEF  = 64;

    localparam logic [19:0] LH_MAX  = 20'hFFFFF;
    localparam logic [23:0] Q24_MAX = 24'hFFFFFF;

    localparam logic [2:0] FACE_EAST  = 3'd0;
    localparam logic [2:0] FACE_WEST  = 3'd1;
    localparam logic [2:0] FACE_SOUTH = 3'd2;
    localparam logic [2:0] FACE_NORTH = 3'd3;
    localparam logic [2:0] TEX_DOOR   = 3'd4;

    typedef struct packed {
        logic [11:0]        column;
        logic [23:0]        player_x;
        logic [23:0]        player_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [23:0]        perp_dist;
        logic               side;
        logic               hit_door;
    } item_t;

    typedef struct packed {
        logic [11:0] column_out;
        logic [19:0] slice_height;
        logic [9:0]  row_top;
        logic [9:0]  row_bottom;
        logic [2:0]  tex_id;
        logic        solid_fill;
        logic [5:0]  tex_col;
        logic [23:0] tex_step;
        logic [23:0] tex_start;
    } result_t;

    // Per-stage record of one item as it moves down the pipeline.
    typedef struct packed {
        logic [11:0] column;
        logic        solid;
        logic        mirror;
        logic [2:0]  tex_id;
        logic [23:0] pdist;
        logic [29:0] frac;
        logic [43:0] acc;
        logic [7:0]  col;
        logic [23:0] rem;
        logic [31:0] quo;
        logic [19:0] lh;
        logic [9:0]  start;
        logic [9:0]  stop;
        logic [19:0] toff;
        logic [23:0] step;
        logic [23:0] tstart;
    } ctx_t;

endpackage

/* design/raycast_wall_column_setup.sv */
// Top level of the wall column setup block: a bit-per-stage divider pipeline.
//
// One item per screen column enters on item_data, qualified by item_valid and
// accepted when item_stall is low. One result leaves on result_data under
// result_valid and is taken when result_stall is low.
// The datapath is a single pipeline of
// 3 + (clog2(SCREEN_HEIGHT+1) + 16) + 1 + (clog2(TEXTURE_SIZE+1) + 16) + 3
// register stages, 57 with the default parameters. The two restoring
// dividers (line height, texture step) produce one quotient bit per stage and
// set that depth. It takes one item per cycle unless the pipeline is frozen.
// While the receiver holds result_stall with a result pending, the whole
// pipeline freezes and item_stall is raised; no item is lost or repeated.
// The user must write the door texture flag (cfg_we, cfg_wdata) only while idle;
// the block does not enforce it. Reset clears all valid bits and the door flag.
`timescale 1ns / 1ps
module raycast_wall_column_setup #(
    parameter int SCREEN_HEIGHT = rwcs_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEXTURE_SIZE  = rwcs_pkg::TEXTURE_SIZE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             item_valid,
    output logic             item_stall,
    input  rwcs_pkg::item_t  item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output rwcs_pkg::result_t result_data
);
    import rwcs_pkg::*;

    localparam int HW  = $clog2(SCREEN_HEIGHT + 1);
    localparam int N1  = HW + 16;
    localparam int TSW = $clog2(TEXTURE_SIZE + 1);
    localparam int N2  = TSW + 16;
    localparam int KD1 = 3;
    localparam int KA  = KD1 + N1;
    localparam int KD2 = KA + 1;
    localparam int KB  = KD2 + N2;
    localparam int KC  = KB + 1;
    localparam int KO  = KC + 1;
    localparam int L   = KO + 1;

    localparam logic [N1-1:0] NUM1 = N1'(SCREEN_HEIGHT) << 16;
    localparam logic [N2-1:0] NUM2 = N2'(TEXTURE_SIZE) << 16;
    localparam logic [20:0]   HALF = 21'(SCREEN_HEIGHT / 2);
    localparam logic [20:0]   HMAX = 21'(SCREEN_HEIGHT - 1);
    localparam logic [7:0]    TMAX = 8'(TEXTURE_SIZE - 1);

    logic   door_tex_present_reg;
    logic   v_reg [L];
    ctx_t   c_reg [L];
    ctx_t   c_next [L];
    logic   adv;

    assign adv        = !(v_reg[L-1] && result_stall);
    assign item_stall = !adv;

    always_comb
    begin
        ctx_t               c;
        logic [23:0]        d;
        logic signed [15:0] dsel;
        logic signed [40:0] mp;
        logic [37:0]        tprod;
        logic [24:0]        r1;
        logic [20:0]        r2;
        logic               ge;
        logic [20:0]        lh2;
        logic [20:0]        hsum;
        for (int k = 0; k < L; k++)
        begin
            c     = (k == 0) ? '0 : c_reg[(k == 0) ? 0 : k - 1];
            d     = '0;
            dsel  = '0;
            mp    = '0;
            tprod = '0;
            r1    = '0;
            r2    = '0;
            ge    = 1'b0;
            lh2   = '0;
            hsum  = '0;
            if (k == 0)
            begin
                d        = (item_data.perp_dist == 24'd0) ? 24'd1 : item_data.perp_dist;
                dsel     = item_data.side ? item_data.dir_x : item_data.dir_y;
                mp       = $signed({17'd0, d}) * dsel;
                c.column = item_data.column;
                c.pdist  = d;
                c.solid  = item_data.hit_door && !door_tex_present_reg;
                c.mirror = item_data.side ? (item_data.dir_y < 0) : (item_data.dir_x > 0);
                if (item_data.hit_door)
                    c.tex_id = TEX_DOOR;
                else if (item_data.side)
                    c.tex_id = (item_data.dir_y > 0) ? FACE_SOUTH : FACE_NORTH;
                else
                    c.tex_id = (item_data.dir_x > 0) ? FACE_EAST : FACE_WEST;
                c.frac = item_data.side ? {item_data.player_x[15:0], 14'd0}
                                        : {item_data.player_y[15:0], 14'd0};
                c.acc  = {14'd0, mp[29:0]};
            end
            else if (k == 1)
            begin
                c.frac = c.frac + c.acc[29:0];
            end
            else if (k == 2)
            begin
                tprod = 38'(c.frac) * 38'(TEXTURE_SIZE);
                c.col = tprod[37:30];
                if (c.mirror)
                    c.col = TMAX - c.col;
                if (c.col > TMAX)
                    c.col = TMAX;
                c.rem = '0;
                c.quo = '0;
            end
            else if (k < KA)
            begin
                r1    = {c.rem, NUM1[N1 - 1 - ((k < KA) ? k - KD1 : 0)]};
                ge    = r1 >= {1'b0, c.pdist};
                c.rem = ge ? 24'(r1 - {1'b0, c.pdist}) : r1[23:0];
                c.quo = {c.quo[30:0], ge};
            end
            else if (k == KA)
            begin
                c.lh  = (c.quo > 32'(LH_MAX)) ? LH_MAX : c.quo[19:0];
                lh2   = 21'(c.lh >> 1);
                hsum  = HALF + lh2;
                c.start = (lh2 >= HALF) ? 10'd0 : 10'(HALF - lh2);
                c.stop  = (hsum >= 21'(SCREEN_HEIGHT)) ? 10'(HMAX) : 10'(hsum);
                c.toff  = (lh2 >= HALF) ? 20'(lh2 - HALF) : 20'd0;
                c.rem = '0;
                c.quo = '0;
            end
            else if (k < KB)
            begin
                r2    = {c.rem[19:0], NUM2[N2 - 1 - ((k < KB) ? k - KD2 : 0)]};
                ge    = r2 >= {1'b0, c.lh};
                c.rem = {4'd0, (ge ? 20'(r2 - {1'b0, c.lh}) : r2[19:0])};
                c.quo = {c.quo[30:0], ge};
            end
            else if (k == KB)
            begin
                if (c.lh == 20'd0)
                    c.step = '0;
                else
                    c.step = (c.quo > 32'(Q24_MAX)) ? Q24_MAX : c.quo[23:0];
            end
            else if (k == KC)
            begin
                c.acc = 44'(c.toff) * 44'(c.step);
            end
            else
            begin
                c.tstart = (c.acc > 44'(Q24_MAX)) ? Q24_MAX : c.acc[23:0];
                if (c.solid)
                begin
                    c.col    = '0;
                    c.step   = '0;
                    c.tstart = '0;
                end
            end
            c_next[k] = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_tex_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            door_tex_present_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= item_valid;
            for (int k = 1; k < L; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < L; k++)
                c_reg[k] <= c_next[k];
        end
    end

    assign result_valid             = v_reg[L-1];
    assign result_data.column_out   = c_reg[L-1].column;
    assign result_data.slice_height = c_reg[L-1].lh;
    assign result_data.row_top      = c_reg[L-1].start;
    assign result_data.row_bottom   = c_reg[L-1].stop;
    assign result_data.tex_id       = c_reg[L-1].tex_id;
    assign result_data.solid_fill   = c_reg[L-1].solid;
    assign result_data.tex_col      = c_reg[L-1].col[5:0];
    assign result_data.tex_step     = c_reg[L-1].step;
    assign result_data.tex_start    = c_reg[L-1].tstart;

endmodule

/* design/rwcs_checker.sv */
// Port-level checker for the wall column setup block and its bind statement.
`timescale 1ns / 1ps
module rwcs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input rwcs_pkg::result_t result_data
);
    import rwcs_pkg::*;

    // A result held by the receiver stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // Rows of a slice are ordered.
    a_rows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.row_top <= result_data.row_bottom)
        else $error("row_top beyond row_bottom");

    // A solid door carries the door code and no texture stepping.
    a_solid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.solid_fill |->
            result_data.tex_id == TEX_DOOR && result_data.tex_step == 24'd0
            && result_data.tex_start == 24'd0)
        else $error("solid fill with texture data");

    // A far wall has no texture step.
    a_far: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.slice_height == 20'd0 |-> result_data.tex_step == 24'd0)
        else $error("step nonzero at zero height");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result valid after reset");

endmodule

bind raycast_wall_column_setup rwcs_checker u_rwcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

/* verif/tb_raycast_wall_column_setup.sv */
// Self-checking testbench for the raycaster wall column setup block.
`timescale 1ns / 1ps
module tb_raycast_wall_column_setup;
    import rwcs_pkg::*;

    localparam longint unsigned SCR_H   = SCREEN_HEIGHT_DEF;
    localparam longint unsigned TEX_SZ  = TEXTURE_SIZE_DEF;
    localparam int              DRAIN_CYCLES = 64;

    logic    clk;
    logic    rst_n;
    logic    cfg_we;
    logic    cfg_wdata;
    logic    item_valid;
    logic    item_stall;
    item_t   item_data;
    logic    result_valid;
    logic    result_stall;
    result_t result_data;

    result_t slice_q[$];
    bit      door_tex_loaded;
    bit      idle_on;
    bit      failed;
    int      stall_left;

    raycast_wall_column_setup u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_data   (item_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data)
    );

    always #5 clk = ~clk;

    function automatic result_t predict_slice(item_t it, bit door_on);
        result_t r;
        longint unsigned pdist, lh, half, start, stop, col, step, tstart;
        longint wall;
        logic [63:0] frac;
        bit mirror, solid;
        logic [2:0] tex;
        half = SCR_H / 2;
        pdist = (it.perp_dist == 0) ? 1 : it.perp_dist;
        lh = (SCR_H << 16) / pdist;
        if (lh > LH_MAX)
            lh = LH_MAX;
        start = (lh / 2 >= half) ? 0 : half - lh / 2;
        stop = half + lh / 2;
        if (stop >= SCR_H)
            stop = SCR_H - 1;
        if (it.side == 1'b0)
        begin
            tex = ($signed(it.dir_x) > 0) ? FACE_EAST : FACE_WEST;
            wall = (longint'(it.player_y) << 14) + longint'(pdist) * longint'($signed(it.dir_y));
            mirror = $signed(it.dir_x) > 0;
        end
        else
        begin
            tex = ($signed(it.dir_y) > 0) ? FACE_SOUTH : FACE_NORTH;
            wall = (longint'(it.player_x) << 14) + longint'(pdist) * longint'($signed(it.dir_x));
            mirror = $signed(it.dir_y) < 0;
        end
        frac = wall & 64'h3FFF_FFFF;
        col = (frac * TEX_SZ) >> 30;
        if (mirror)
            col = TEX_SZ - col - 1;
        if (col >= TEX_SZ)
            col = TEX_SZ - 1;
        solid = it.hit_door && !door_on;
        if (it.hit_door)
            tex = TEX_DOOR;
        step = 0;
        tstart = 0;
        if (lh != 0)
        begin
            step = (TEX_SZ << 16) / lh;
            if (step > Q24_MAX)
                step = Q24_MAX;
            tstart = (start + lh / 2 - half) * step;
            if (tstart > Q24_MAX)
                tstart = Q24_MAX;
        end
        if (solid)
        begin
            col = 0;
            step = 0;
            tstart = 0;
        end
        r.column_out   = it.column;
        r.slice_height = lh[19:0];
        r.row_top      = start[9:0];
        r.row_bottom   = stop[9:0];
        r.tex_id       = tex;
        r.solid_fill   = solid;
        r.tex_col      = col[5:0];
        r.tex_step     = step[23:0];
        r.tex_start    = tstart[23:0];
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1;
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (slice_q.size() == 0)
            begin
                $error("result for column %0d arrived with nothing expected",
                       result_data.column_out);
                failed = 1;
            end
            else
            begin
                e = slice_q.pop_front();
                check_field("column_out", e.column_out, result_data.column_out);
                check_field("slice_height", e.slice_height, result_data.slice_height);
                check_field("row_top", e.row_top, result_data.row_top);
                check_field("row_bottom", e.row_bottom, result_data.row_bottom);
                check_field("tex_id", e.tex_id, result_data.tex_id);
                check_field("solid_fill", e.solid_fill, result_data.solid_fill);
                check_field("tex_col", e.tex_col, result_data.tex_col);
                check_field("tex_step", e.tex_step, result_data.tex_step);
                check_field("tex_start", e.tex_start, result_data.tex_start);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic send_item(item_t it);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        slice_q.push_back(predict_slice(it, door_tex_loaded));
    endtask

    task automatic drain_pipeline();
        item_valid <= 1'b0;
        while (slice_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_door_tex(bit v);
        drain_pipeline();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        door_tex_loaded = v;
    endtask

    function automatic item_t random_hit();
        item_t it;
        it.column   = 12'($urandom_range(0, 4095));
        it.player_x = 24'($urandom_range(0, 24'hFFFFFF));
        it.player_y = 24'($urandom_range(0, 24'hFFFFFF));
        it.dir_x    = 16'($urandom_range(0, 16'hFFFF));
        it.dir_y    = 16'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 5))
            0: it.perp_dist = 24'($urandom_range(0, 80));
            1: it.perp_dist = 24'($urandom_range(0, 24'h3FFFF));
            2: it.perp_dist = 24'($urandom_range(24'h8000, 24'h40000));
            default: it.perp_dist = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        if ($urandom_range(0, 9) == 0)
            it.dir_x = '0;
        if ($urandom_range(0, 9) == 0)
            it.dir_y = '0;
        it.side     = 1'($urandom_range(0, 1));
        it.hit_door = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    task automatic test_directed();
        item_t it;
        int    k;
        logic [23:0] dists[8] = '{24'd0, 24'd1, 24'd64, 24'd65, 24'h10000,
                                   24'h2000, 24'hFFFFFF, 24'h0FFFFF};
        for (k = 0; k < 8; k++)
        begin
            it = random_hit();
            it.perp_dist = dists[k];
            it.side = k[0];
            it.hit_door = 1'b0;
            it.dir_x = k[1] ? 16'sh7FFF : -16'sh8000;
            it.dir_y = k[2] ? -16'sh8000 : 16'sh7FFF;
            it.player_x = (k < 4) ? 24'hFFFFFF : 24'h0;
            it.player_y = (k < 4) ? 24'h0 : 24'hFFFFFF;
            it.column = (k < 4) ? 12'hFFF : 12'h0;
            send_item(it);
        end
        for (k = 0; k < 4; k++)
        begin
            it = random_hit();
            it.side = k[0];
            it.dir_x = k[1] ? 16'sd0 : 16'sd100;
            it.dir_y = k[1] ? -16'sd100 : 16'sd0;
            it.hit_door = 1'b0;
            send_item(it);
        end
        for (k = 0; k < 2; k++)
        begin
            it = random_hit();
            it.hit_door = 1'b1;
            it.side = k[0];
            send_item(it);
        end
        write_door_tex(1'b1);
        for (k = 0; k < 4; k++)
        begin
            it = random_hit();
            it.hit_door = 1'b1;
            it.side = k[0];
            it.perp_dist = k[1] ? 24'd0 : 24'hFFFFFF;
            send_item(it);
        end
        write_door_tex(1'b0);
    endtask

    task automatic test_random(int count, bit door_on);
        int k;
        write_door_tex(door_on);
        for (k = 0; k < count; k++)
        begin
            send_item(random_hit());
            if (k == count / 2 && door_on)
            begin
                item_valid <= 1'b0;
                while (slice_q.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        item_valid = 1'b0;
        item_data = '0;
        result_stall = 1'b0;
        stall_left = 0;
        idle_on = 1'b1;
        failed = 1'b0;
        door_tex_loaded = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500, 1'b1);
        test_random(500, 1'b0);
        test_random(300, 1'b1);
        idle_on = 1'b0;
        test_random(400, 1'b0);
        drain_pipeline();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
